FILE: rtl/core/log_linear_latency_histogram_core_defines.svh
// assertion macros shared by the histogram core rtl
// no dependencies; included by the top level only
`ifndef LOG_LINEAR_LATENCY_HISTOGRAM_CORE_DEFINES_SVH
`define LOG_LINEAR_LATENCY_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define LLH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/llh_pkg.sv
// shared types, widths and helpers for the log-linear latency histogram core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package llh_pkg;

   localparam int SAMPLE_W             = 64;
   localparam int BUCKET_W             = 10;
   localparam int COUNT_W              = 32;
   localparam int MSB_W                = 6;
   localparam int SUB_BITS             = 4;
   localparam int SUBS_PER_OCTAVE      = 1 << SUB_BITS;
   localparam int TOP_EXPONENT_DEFAULT = 39;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_ADDR  = 4'b0100,
      ST_LOOK  = 4'b1000
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/llh_ram.sv
// generic one-write one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module llh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/llh_bucket_map.sv
// maps a 64-bit sample to its log-linear bucket index over two steps
// depends on llh_pkg
`timescale 1ns / 1ps
`default_nettype none

module llh_bucket_map #(
   parameter int TOP_EXPONENT = llh_pkg::TOP_EXPONENT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [llh_pkg::SAMPLE_W-1:0]  sample,
   output logic [llh_pkg::BUCKET_W-1:0]  bucket
);
   import llh_pkg::*;

   localparam logic [SAMPLE_W-1:0] TOP_BASE = SAMPLE_W'(1) << TOP_EXPONENT;
   localparam logic [SAMPLE_W-1:0] TOP_WIDTH =
      ({SAMPLE_W{1'b1}} - TOP_BASE) / SAMPLE_W'(SUBS_PER_OCTAVE);
   localparam logic [MSB_W-1:0] TOP_E = MSB_W'(TOP_EXPONENT);

   // first step: leading one and top-octave threshold compares
   logic [SUBS_PER_OCTAVE-2:0] ge;
   logic [MSB_W-1:0]           msb;
   logic [SUB_BITS-1:0]        top_sub;

   for (genvar k = 1; k < SUBS_PER_OCTAVE; k++) begin : g_thr
      localparam logic [SAMPLE_W-1:0] THR = TOP_BASE + SAMPLE_W'(k) * TOP_WIDTH;
      assign ge[k-1] = (sample >= THR);
   end

   always_comb begin
      msb = '0;
      for (int i = 0; i < SAMPLE_W; i++) begin
         if (sample[i]) begin
            msb = MSB_W'(i);
         end
      end
   end

   // thresholds rise, so the last one passed is the sub-bucket
   always_comb begin
      top_sub = '0;
      for (int k = 0; k < SUBS_PER_OCTAVE - 1; k++) begin
         if (ge[k]) begin
            top_sub = SUB_BITS'(k + 1);
         end
      end
   end

   logic                  zero_ff;
   logic [MSB_W-1:0]      msb_ff;
   logic [SUB_BITS-1:0]   top_sub_ff;
   logic [SAMPLE_W-1:0]   sample_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         zero_ff    <= (sample == '0);
         msb_ff     <= msb;
         top_sub_ff <= top_sub;
         sample_ff  <= sample;
      end
   end

   // second step: linear split of the octave
   logic [SAMPLE_W-1:0] shifted;
   logic [SUB_BITS-1:0] low_sub;
   logic [SUB_BITS-1:0] sub;
   logic [MSB_W-1:0]    expo;

   always_comb begin
      shifted = sample_ff >> (msb_ff - MSB_W'(SUB_BITS));
      if (msb_ff >= MSB_W'(SUB_BITS)) begin
         low_sub = shifted[SUB_BITS-1:0];
      end else begin
         // narrow octave: one value per sub-bucket
         low_sub = sample_ff[SUB_BITS-1:0] & ~({SUB_BITS{1'b1}} << msb_ff);
      end
      if (msb_ff >= TOP_E) begin
         expo = TOP_E;
         sub  = top_sub_ff;
      end else begin
         expo = msb_ff;
         sub  = low_sub;
      end
      if (zero_ff) begin
         bucket = '0;
      end else begin
         bucket = {expo, sub};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/log_linear_latency_histogram_core.sv
// log-linear latency histogram core: top level, counter store and control
// depends on llh_pkg, llh_bucket_map, llh_ram and the assertion header
// response: registered through the address and look states after the request is taken,
//   later while an earlier response is still held by a response stall
// flow: a new transaction is taken only once the last is through (accept, ram read,
//   update), set by the single counter ram read-modify-write with one item in flight
// reset: synchronous; afterwards a clearing pass zeroes every counter, one per
//   cycle, all (TOP_EXPONENT+1)*16 counters (640 by default), with requests stalled
`timescale 1ns / 1ps
`default_nettype none
`include "log_linear_latency_histogram_core_defines.svh"

module log_linear_latency_histogram_core #(
   parameter int TOP_EXPONENT = llh_pkg::TOP_EXPONENT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [llh_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [llh_pkg::BUCKET_W-1:0] req_read_bucket,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [llh_pkg::BUCKET_W-1:0] rsp_bucket_hit,
   output logic [llh_pkg::COUNT_W-1:0]  rsp_bucket_count,
   output logic [llh_pkg::COUNT_W-1:0]  rsp_total_count
);
   import llh_pkg::*;

   localparam int DEPTH = (TOP_EXPONENT + 1) * SUBS_PER_OCTAVE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [BUCKET_W:0] DEPTH_EXT = (BUCKET_W + 1)'(DEPTH);

   // control and payload registers
   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   op_type                 op_ff;
   logic [BUCKET_W-1:0]    rb_ff;
   logic [AW-1:0]          addr_ff;
   logic                   rd_ok_ff;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0]    rsp_hit_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic [COUNT_W-1:0]     rsp_total_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   finish;
   logic [BUCKET_W-1:0]    map_bucket;

   // counter ram ports
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [COUNT_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [COUNT_W-1:0]     ram_rd_data;
   logic [COUNT_W-1:0]     cnt_new;

   // one transaction in flight; the next waits in idle
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // the output register is free once empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == ST_LOOK) && out_free;

   // sample to bucket index, first step on accept, second in the address state
   llh_bucket_map #(
      .TOP_EXPONENT (TOP_EXPONENT)
   ) u_map (
      .clock  (clock),
      .load   (req_accept),
      .sample (req_sample),
      .bucket (map_bucket)
   );

   // read in the address state, write back in the look state, so the single
   // item in flight never sees a read and write of the same entry overlap
   assign ram_rd_en   = (state_ff == ST_ADDR);
   assign ram_rd_addr = (op_ff == OP_READ) ? rb_ff[AW-1:0] : map_bucket[AW-1:0];

   assign cnt_new     = sat_inc(ram_rd_data);
   assign ram_wr_en   = (state_ff == ST_CLEAR) || (finish && (op_ff == OP_RECORD));
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : cnt_new;

   llh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // total counter and response valid
   always_comb begin
      total_in = total_ff;
      if (finish && (op_ff == OP_RECORD)) begin
         total_in = sat_inc(total_ff);
      end
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff <= op_type'(req_op);
         rb_ff <= req_read_bucket;
      end
      if (ram_rd_en) begin
         addr_ff  <= ram_rd_addr;
         // records always land in range; reads beyond the store return zero
         rd_ok_ff <= (op_ff == OP_RECORD) || ({1'b0, rb_ff} < DEPTH_EXT);
      end
      if (finish) begin
         if (op_ff == OP_RECORD) begin
            rsp_hit_ff   <= BUCKET_W'(addr_ff);
            rsp_count_ff <= cnt_new;
            rsp_total_ff <= total_in;
         end else begin
            rsp_hit_ff   <= '0;
            rsp_count_ff <= rd_ok_ff ? ram_rd_data : '0;
            rsp_total_ff <= total_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_hit   = rsp_hit_ff;
   assign rsp_bucket_count = rsp_count_ff;
   assign rsp_total_count  = rsp_total_ff;

   // checks
   `LLH_ASSERT_NEXT(a_read_then_look, clock, reset, ram_rd_en, state_ff == ST_LOOK,
                    "ram read not followed by update state")
   `LLH_ASSERT_SAME(a_hit_in_range, clock, reset, rsp_valid_ff,
                    {1'b0, rsp_hit_ff} < DEPTH_EXT, "bucket hit beyond counter store")
   `LLH_ASSERT_NEXT(a_total_monotone, clock, reset, state_ff != ST_CLEAR,
                    total_ff >= $past(total_ff), "total counter decreased")

endmodule

`default_nettype wire
